// ----- rtl/mau_pkg.sv -----
// ============================================================================
// mau_pkg
// Shared constants and types for the modulo-1000000007 arithmetic unit.
// ============================================================================
package mau_pkg;

    localparam int RES_W      = 30;
    localparam int RAW_W      = 64;
    localparam int EXP_BITS   = 63;
    localparam int PAD_W      = RAW_W - RES_W;
    localparam int MUL_CNT_W  = $clog2(RAW_W + 1);
    localparam int EXP_CNT_W  = $clog2(EXP_BITS + 1);

    localparam logic [RES_W-1:0]     MODULUS    = RES_W'(1000000007);
    localparam logic [RES_W+1:0]     MODULUS_X1 = (RES_W + 2)'(1000000007);
    localparam logic [RES_W+1:0]     MODULUS_X2 = (RES_W + 2)'(2000000014);
    localparam logic [RAW_W-1:0]     MOD_M2_FULL = RAW_W'(1000000005);
    localparam logic [EXP_BITS-1:0]  INV_EXP    = MOD_M2_FULL[EXP_BITS-1:0];

    localparam logic [MUL_CNT_W-1:0] NB_RESIDUE = MUL_CNT_W'(RES_W);
    localparam logic [MUL_CNT_W-1:0] NB_RAW     = MUL_CNT_W'(RAW_W);

    localparam logic [2:0] OP_REDUCE   = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_SUBTRACT = 3'd2;
    localparam logic [2:0] OP_MULTIPLY = 3'd3;
    localparam logic [2:0] OP_POWER    = 3'd4;
    localparam logic [2:0] OP_INVERSE  = 3'd5;
    localparam logic [2:0] OP_DIVIDE   = 3'd6;

    typedef struct packed {
        logic                 start;
        logic [MUL_CNT_W-1:0] nbits;
    } mul_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

// ----- rtl/mau_mulmod.sv -----
// ============================================================================
// mau_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle,
// MSB first, with the running sum kept below the modulus.
// ============================================================================
module mau_mulmod
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mau_pkg::mul_cmd_t           cmd,
    input  logic [mau_pkg::RES_W-1:0]   mcand,
    input  logic [mau_pkg::RAW_W-1:0]   mplier,
    output mau_pkg::mul_sts_t           sts,
    output logic [mau_pkg::RES_W-1:0]   product
);
    import mau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0]     acc_reg, acc_next;
    logic [RES_W-1:0]     mcand_reg, mcand_next;
    logic [RAW_W-1:0]     sh_reg, sh_next;
    logic [RES_W+1:0]     sum;
    logic [RES_W+1:0]     sum_red;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (sh_reg[RAW_W-1] ? {2'b00, mcand_reg} : '0);
        priority if (sum >= MODULUS_X2)
        begin
            sum_red = sum - MODULUS_X2;
        end
        else if (sum >= MODULUS_X1)
        begin
            sum_red = sum - MODULUS_X1;
        end
        else
        begin
            sum_red = sum;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        sh_next    = sh_reg;
        if (cmd.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = cmd.nbits;
            acc_next   = '0;
            mcand_next = mcand;
            sh_next    = mplier;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[RES_W-1:0];
            sh_next  = {sh_reg[RAW_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        sh_reg    <= sh_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

`ifndef SYNTHESIS
    a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg < MODULUS))
        else $error("mulmod result not reduced");
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("mulmod done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("mulmod started while in use");
`endif

endmodule

// ----- rtl/modular_arithmetic_unit_core.sv -----
// ============================================================================
// modular_arithmetic_unit_core
// Arithmetic unit modulo 1000000007: reduce, add, subtract, multiply, power,
// inverse and divide, one result per transaction.
// ============================================================================
// One transaction at a time; every multiplication runs through one bit-serial
// modular multiplier that takes one operand bit per cycle, so the multiplier
// sets the latency of the operations that use it. Add, subtract and unused
// codes do not use it; multiply runs it over the residue width and reduce over
// the 64 bits of the magnitude. Power walks all 63 exponent bits, each bit
// costing a squaring plus a multiply by the base when the bit is set.
// Inverse uses exponent 1000000005 and divide adds one multiply on top.
// A new transaction is accepted once the previous result has moved to the
// output register.
// ============================================================================
module modular_arithmetic_unit_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [2:0]                      operation,
    input  logic [mau_pkg::RES_W-1:0]       left_operand,
    input  logic [mau_pkg::RES_W-1:0]       right_operand,
    input  logic signed [mau_pkg::RAW_W-1:0] raw_value,
    input  logic [mau_pkg::EXP_BITS-1:0]    exponent,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [mau_pkg::RES_W-1:0]       residue_result
);
    import mau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_START = 8'b0000_0010,
        S_RED_W = 8'b0000_0100,
        S_MUL_W = 8'b0000_1000,
        S_SQ    = 8'b0001_0000,
        S_SQ_W  = 8'b0010_0000,
        S_MB_W  = 8'b0100_0000,
        S_STEP  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [RES_W-1:0]     left_reg, left_next;
    logic [RES_W-1:0]     right_reg, right_next;
    logic [RES_W-1:0]     base_reg, base_next;
    logic [RES_W-1:0]     acc_reg, acc_next;
    logic [RAW_W-1:0]     raw_reg, raw_next;
    logic [EXP_BITS-1:0]  exp_reg, exp_next;
    logic [EXP_CNT_W-1:0] ecnt_reg, ecnt_next;
    logic [RES_W-1:0]     res_reg, res_next;
    logic                 res_ready_reg, res_ready_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     out_data_reg, out_data_next;

    logic                 accept;
    logic [RES_W-1:0]     left_fold;
    logic [RES_W-1:0]     right_fold;
    logic [RAW_W-1:0]     raw_mag;
    logic [RES_W:0]       add_sum;
    logic [RES_W:0]       sub_sum;

    mul_cmd_t             mul_cmd;
    mul_sts_t             mul_sts;
    logic [RES_W-1:0]     mul_mcand;
    logic [RAW_W-1:0]     mul_mplier;
    logic [RES_W-1:0]     mul_product;

    mau_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .sts     (mul_sts),
        .product (mul_product)
    );

    assign item_stall = (state_reg != S_IDLE) || res_ready_reg;
    assign accept     = item_valid && !item_stall;

    assign left_fold  = (left_operand  >= MODULUS) ? left_operand  - MODULUS : left_operand;
    assign right_fold = (right_operand >= MODULUS) ? right_operand - MODULUS : right_operand;
    assign raw_mag    = raw_reg[RAW_W-1] ? (~raw_reg + 1'b1) : raw_reg;
    assign add_sum    = {1'b0, left_reg} + {1'b0, right_reg};
    assign sub_sum    = {1'b0, left_reg} + {1'b0, MODULUS} - {1'b0, right_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        raw_next       = raw_reg;
        exp_next       = exp_reg;
        ecnt_next      = ecnt_reg;
        res_next       = res_reg;
        // pending result stays until the output register is free to take it
        res_ready_next = res_ready_reg && out_valid_reg && result_stall;
        mul_cmd.start  = 1'b0;
        mul_cmd.nbits  = NB_RESIDUE;
        mul_mcand      = acc_reg;
        mul_mplier     = {acc_reg, {PAD_W{1'b0}}};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = operation;
                    left_next  = left_fold;
                    right_next = right_fold;
                    raw_next   = raw_value;
                    base_next  = (operation == OP_DIVIDE) ? right_fold : left_fold;
                    exp_next   = (operation == OP_POWER) ? exponent : INV_EXP;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                acc_next  = RES_W'(1);
                ecnt_next = EXP_CNT_W'(EXP_BITS);
                unique case (op_reg)
                    OP_REDUCE:
                    begin
                        mul_cmd.start = 1'b1;
                        mul_cmd.nbits = NB_RAW;
                        mul_mcand     = RES_W'(1);
                        mul_mplier    = raw_mag;
                        state_next    = S_RED_W;
                    end
                    OP_ADD:
                    begin
                        res_next       = (add_sum >= {1'b0, MODULUS})
                                       ? RES_W'(add_sum - {1'b0, MODULUS})
                                       : add_sum[RES_W-1:0];
                        res_ready_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    OP_SUBTRACT:
                    begin
                        res_next       = (sub_sum >= {1'b0, MODULUS})
                                       ? RES_W'(sub_sum - {1'b0, MODULUS})
                                       : sub_sum[RES_W-1:0];
                        res_ready_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    OP_MULTIPLY:
                    begin
                        mul_cmd.start = 1'b1;
                        mul_mcand     = left_reg;
                        mul_mplier    = {right_reg, {PAD_W{1'b0}}};
                        state_next    = S_MUL_W;
                    end
                    OP_POWER, OP_INVERSE, OP_DIVIDE:
                    begin
                        state_next = S_SQ;
                    end
                    default:
                    begin
                        res_next       = '0;
                        res_ready_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            S_RED_W:
            begin
                if (mul_sts.done)
                begin
                    res_next       = (raw_reg[RAW_W-1] && (mul_product != '0))
                                   ? MODULUS - mul_product : mul_product;
                    res_ready_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MUL_W:
            begin
                if (mul_sts.done)
                begin
                    res_next       = mul_product;
                    res_ready_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SQ:
            begin
                mul_cmd.start = 1'b1;
                state_next    = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (mul_sts.done)
                begin
                    acc_next = mul_product;
                    if (exp_reg[EXP_BITS-1])
                    begin
                        mul_cmd.start = 1'b1;
                        mul_mcand     = base_reg;
                        mul_mplier    = {mul_product, {PAD_W{1'b0}}};
                        state_next    = S_MB_W;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
            end
            S_MB_W:
            begin
                if (mul_sts.done)
                begin
                    acc_next   = mul_product;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                exp_next  = exp_reg << 1;
                ecnt_next = ecnt_reg - 1'b1;
                if (ecnt_reg == EXP_CNT_W'(1))
                begin
                    if (op_reg == OP_DIVIDE)
                    begin
                        mul_cmd.start = 1'b1;
                        mul_mcand     = left_reg;
                        state_next    = S_MUL_W;
                    end
                    else
                    begin
                        res_next       = acc_reg;
                        res_ready_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: takes the pending result whenever its slot frees up
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        if (res_ready_reg && !(out_valid_reg && result_stall))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ecnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_ready_reg <= res_ready_next;
            out_valid_reg <= out_valid_next;
            ecnt_reg      <= ecnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        raw_reg      <= raw_next;
        exp_reg      <= exp_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid   = out_valid_reg;
    assign residue_result = out_data_reg;

`ifndef SYNTHESIS
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg < MODULUS))
        else $error("result not reduced");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_sts.done |-> (state_reg == S_RED_W || state_reg == S_MUL_W
                          || state_reg == S_SQ_W || state_reg == S_MB_W))
        else $error("multiplier finished with nobody waiting");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_START))
        else $error("accepted transaction not started");
`endif

endmodule
